// File: rtl/slcc_pkg.sv
// Package for the status LED colour controller.
// Holds the item kind and status codes, the colour type and the status colour table.
// It depends on nothing.
package slcc_pkg;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned BLINK_W     = 16;
  localparam int unsigned REG_BLINK_INTERVAL = 0;

  typedef enum logic [2:0] {
    KIND_AGGREGATE     = 3'd0,
    KIND_SINGLE        = 3'd1,
    KIND_TICK          = 3'd2,
    KIND_RGB           = 3'd3,
    KIND_WHEEL         = 3'd4,
    KIND_SET_STATUS    = 3'd5,
    KIND_BLINK_RESTART = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_OFF          = 3'd0,
    ST_IDLE         = 3'd1,
    ST_MOVING       = 3'd2,
    ST_ERROR        = 3'd3,
    ST_STALL        = 3'd4,
    ST_INITIALIZING = 3'd5,
    ST_DISABLED     = 3'd6,
    ST_WARNING      = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       stall_flag;
    logic       moving_flag;
    logic       enabled_flag;
    logic       initialized_flag;
    logic       index_valid;
    logic       last_report;
    logic [7:0] rgb_red;
    logic [7:0] rgb_green;
    logic [7:0] rgb_blue;
    logic [7:0] wheel_pos;
    logic [2:0] status_code;
  } in_item_t;

  function automatic rgb_t status_color(input status_t s);
    rgb_t c;
    unique case (s)
      ST_OFF:          c = '{8'd0,   8'd0,   8'd0};
      ST_IDLE:         c = '{8'd0,   8'd255, 8'd0};
      ST_MOVING:       c = '{8'd0,   8'd0,   8'd255};
      ST_ERROR:        c = '{8'd255, 8'd0,   8'd0};
      ST_STALL:        c = '{8'd255, 8'd255, 8'd0};
      ST_INITIALIZING: c = '{8'd0,   8'd255, 8'd255};
      ST_DISABLED:     c = '{8'd255, 8'd165, 8'd0};
      ST_WARNING:      c = '{8'd255, 8'd0,   8'd255};
      default:         c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/slcc_stream_if.sv
// Valid/ready channel interfaces for the status LED colour controller.
// One carries input items, the other result items; both use plain logic fields.
interface slcc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       stall_flag;
  logic       moving_flag;
  logic       enabled_flag;
  logic       initialized_flag;
  logic       index_valid;
  logic       last_report;
  logic [7:0] rgb_red;
  logic [7:0] rgb_green;
  logic [7:0] rgb_blue;
  logic [7:0] wheel_pos;
  logic [2:0] status_code;

  modport source (
    output valid, kind, stall_flag, moving_flag, enabled_flag, initialized_flag,
           index_valid, last_report, rgb_red, rgb_green, rgb_blue, wheel_pos,
           status_code,
    input  ready
  );
  modport sink (
    input  valid, kind, stall_flag, moving_flag, enabled_flag, initialized_flag,
           index_valid, last_report, rgb_red, rgb_green, rgb_blue, wheel_pos,
           status_code,
    output ready
  );
endinterface

interface slcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic [2:0] shown_status;

  modport source (
    output valid, led_red, led_green, led_blue, shown_status,
    input  ready
  );
  modport sink (
    input  valid, led_red, led_green, led_blue, shown_status,
    output ready
  );
endinterface

// File: rtl/status_led_color_controller_top.sv
// Top level of the status LED colour controller.
// Depends on slcc_pkg and the channel interfaces in slcc_stream_if.sv.
// A result passes through the input register and then the result register, and can be held there by a stall.
// Throughput: one input item per cycle, limited only by the result register being taken.
// Reset (synchronous, rst_n low) clears the status, blink state, flags, interval and both stages.
module status_led_color_controller_top #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  slcc_in_if.sink                          in_ch,
  slcc_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [slcc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [slcc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import slcc_pkg::*;

  localparam int unsigned TW    = TICK_COUNTER_WIDTH;
  localparam int unsigned CMP_W = (TW > BLINK_W) ? TW : BLINK_W;
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  logic [BLINK_W-1:0] blink_interval_r;
  logic               reg_sel;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       s1_adv;

  status_t    status_r, status_nxt;
  logic       phase_r, phase_nxt;
  logic [TW-1:0] ticks_r, ticks_nxt;
  logic       any_stall_r, any_stall_nxt;
  logic       any_moving_r, any_moving_nxt;
  logic       any_disabled_r, any_disabled_nxt;
  logic       any_uninit_r, any_uninit_nxt;

  logic       res_valid;
  rgb_t       res_color;
  logic [2:0] res_status;

  logic       out_valid_r;
  rgb_t       out_color_r;
  logic [2:0] out_status_r;

  logic [TW-1:0] tick_inc;
  logic [7:0]    wheel_inv;
  logic [7:0]    wheel_seg;
  logic [9:0]    wheel_x3;
  status_t       pick;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_BLINK_INTERVAL));
  assign prdata  = reg_sel ? CFG_DATA_W'(blink_interval_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_interval_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      blink_interval_r <= pwdata[BLINK_W-1:0];
    end
  end

  // Input register
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{kind: in_ch.kind, stall_flag: in_ch.stall_flag,
                     moving_flag: in_ch.moving_flag, enabled_flag: in_ch.enabled_flag,
                     initialized_flag: in_ch.initialized_flag,
                     index_valid: in_ch.index_valid, last_report: in_ch.last_report,
                     rgb_red: in_ch.rgb_red, rgb_green: in_ch.rgb_green,
                     rgb_blue: in_ch.rgb_blue, wheel_pos: in_ch.wheel_pos,
                     status_code: in_ch.status_code};
    end
  end

  // Item processing
  assign tick_inc  = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;
  assign wheel_inv = ~s1_item_r.wheel_pos;

  always_comb begin
    priority if (wheel_inv < 8'd85) begin
      wheel_seg = wheel_inv;
    end else if (wheel_inv < 8'd170) begin
      wheel_seg = wheel_inv - 8'd85;
    end else begin
      wheel_seg = wheel_inv - 8'd170;
    end
  end

  assign wheel_x3 = ({2'b00, wheel_seg} << 1) + {2'b00, wheel_seg};

  always_comb begin
    status_nxt       = status_r;
    phase_nxt        = phase_r;
    ticks_nxt        = ticks_r;
    any_stall_nxt    = any_stall_r;
    any_moving_nxt   = any_moving_r;
    any_disabled_nxt = any_disabled_r;
    any_uninit_nxt   = any_uninit_r;
    res_valid        = 1'b0;
    res_color        = '0;
    res_status       = status_r;
    pick             = ST_IDLE;

    unique case (kind_t'(s1_item_r.kind))
      KIND_AGGREGATE: begin
        any_stall_nxt    = any_stall_r    | s1_item_r.stall_flag;
        any_moving_nxt   = any_moving_r   | s1_item_r.moving_flag;
        any_disabled_nxt = any_disabled_r | ~s1_item_r.enabled_flag;
        any_uninit_nxt   = any_uninit_r   | ~s1_item_r.initialized_flag;
        if (s1_item_r.last_report) begin
          priority if (any_stall_nxt) begin
            pick = ST_STALL;
          end else if (any_moving_nxt) begin
            pick = ST_MOVING;
          end else if (any_uninit_nxt) begin
            pick = ST_INITIALIZING;
          end else if (any_disabled_nxt) begin
            pick = ST_DISABLED;
          end else begin
            pick = ST_IDLE;
          end
          any_stall_nxt    = 1'b0;
          any_moving_nxt   = 1'b0;
          any_disabled_nxt = 1'b0;
          any_uninit_nxt   = 1'b0;
          status_nxt = pick;
          res_valid  = 1'b1;
          res_color  = status_color(pick);
          res_status = pick;
        end
      end
      KIND_SINGLE: begin
        priority if (!s1_item_r.index_valid) begin
          pick = ST_ERROR;
        end else if (s1_item_r.stall_flag) begin
          pick = ST_STALL;
        end else if (s1_item_r.moving_flag) begin
          pick = ST_MOVING;
        end else if (!s1_item_r.enabled_flag) begin
          pick = ST_DISABLED;
        end else if (!s1_item_r.initialized_flag) begin
          pick = ST_INITIALIZING;
        end else begin
          pick = ST_IDLE;
        end
        status_nxt = pick;
        res_valid  = 1'b1;
        res_color  = status_color(pick);
        res_status = pick;
      end
      KIND_TICK: begin
        if ((blink_interval_r != '0) &&
            (CMP_W'(tick_inc) >= CMP_W'(blink_interval_r))) begin
          ticks_nxt = '0;
          phase_nxt = ~phase_r;
          res_valid = 1'b1;
          res_color = phase_r ? rgb_t'('0) : status_color(status_r);
        end else begin
          ticks_nxt = tick_inc;
        end
      end
      KIND_RGB: begin
        status_nxt = ST_OFF;
        res_valid  = 1'b1;
        res_color  = '{s1_item_r.rgb_red, s1_item_r.rgb_green, s1_item_r.rgb_blue};
        res_status = ST_OFF;
      end
      KIND_WHEEL: begin
        status_nxt = ST_OFF;
        res_valid  = 1'b1;
        res_status = ST_OFF;
        priority if (wheel_inv < 8'd85) begin
          res_color = '{8'(10'd255 - wheel_x3), 8'd0, wheel_x3[7:0]};
        end else if (wheel_inv < 8'd170) begin
          res_color = '{8'd0, wheel_x3[7:0], 8'(10'd255 - wheel_x3)};
        end else begin
          res_color = '{wheel_x3[7:0], 8'(10'd255 - wheel_x3), 8'd0};
        end
      end
      KIND_SET_STATUS: begin
        status_nxt = status_t'(s1_item_r.status_code);
        res_valid  = 1'b1;
        res_color  = status_color(status_t'(s1_item_r.status_code));
        res_status = s1_item_r.status_code;
      end
      KIND_BLINK_RESTART: begin
        ticks_nxt = '0;
        phase_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r       <= ST_OFF;
      phase_r        <= 1'b0;
      ticks_r        <= '0;
      any_stall_r    <= 1'b0;
      any_moving_r   <= 1'b0;
      any_disabled_r <= 1'b0;
      any_uninit_r   <= 1'b0;
    end else if (s1_adv) begin
      status_r       <= status_nxt;
      phase_r        <= phase_nxt;
      ticks_r        <= ticks_nxt;
      any_stall_r    <= any_stall_nxt;
      any_moving_r   <= any_moving_nxt;
      any_disabled_r <= any_disabled_nxt;
      any_uninit_r   <= any_uninit_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_color_r  <= res_color;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.led_red      = out_color_r.red;
  assign out_ch.led_green    = out_color_r.green;
  assign out_ch.led_blue     = out_color_r.blue;
  assign out_ch.shown_status = out_status_r;

endmodule

// File: rtl/slcc_checker.sv
// Port-level checker for the status LED colour controller, bound to its top level.
// Depends on slcc_pkg and the channel interfaces in slcc_stream_if.sv.
module slcc_checker (
  input logic                             clk,
  input logic                             rst_n,
  slcc_in_if.sink                         in_ch,
  slcc_out_if.source                      out_ch,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [slcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input logic [slcc_pkg::CFG_DATA_W-1:0]  pwdata,
  input logic [slcc_pkg::CFG_DATA_W-1:0]  prdata
);
  import slcc_pkg::*;

  // Both stages are empty after reset, so the input side must be open and no result shown.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (in_ch.ready && !out_ch.valid))
    else $error("channels not empty after reset");

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.led_red) && $stable(out_ch.led_green) &&
       $stable(out_ch.led_blue) && $stable(out_ch.shown_status)))
    else $error("stalled result changed");

  // An error status shows red, or black in the dark blink phase.
  a_error_colour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.shown_status == ST_ERROR) |->
      ((out_ch.led_red == 8'd255 && out_ch.led_green == 8'd0 && out_ch.led_blue == 8'd0) ||
       (out_ch.led_red == 8'd0 && out_ch.led_green == 8'd0 && out_ch.led_blue == 8'd0)))
    else $error("error status with wrong colour");

  // The blink interval reads back what was last written to it.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[CFG_ADDR_W-1:2] == '0) |=>
      (paddr[CFG_ADDR_W-1:2] != '0 ||
       prdata[BLINK_W-1:0] == $past(pwdata[BLINK_W-1:0])))
    else $error("blink interval readback mismatch");

endmodule

bind status_led_color_controller_top slcc_checker u_slcc_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_ch   (in_ch),
  .out_ch  (out_ch),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);

// File: tb/tb.sv
// Self-checking testbench for status_led_color_controller_top: a directed table, then
// random phases under changing blink intervals and idling, scored against a predictor.
// Depends on slcc_pkg and the channel interfaces in slcc_stream_if.sv.
module tb;
  import slcc_pkg::*;

  localparam int unsigned TICK_W       = 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS  = 175;
  localparam logic [2:0]  KIND_UNUSED  = 3'd7;
  localparam logic [15:0] TICK_TOP     = 16'hFFFF;

  typedef enum logic [1:0] {BY_PREDICTOR, BY_TABLE, NO_RESULT} check_mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] status;
  } led_result_t;

  typedef struct {
    in_item_t    item;
    check_mode_t mode;
    led_result_t typed;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  slcc_in_if  in_ch();
  slcc_out_if out_ch();

  status_led_color_controller_top #(.TICK_COUNTER_WIDTH(TICK_W)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state.
  logic [2:0]  shown_code;
  logic        blink_lit;
  logic [15:0] tick_count;
  logic        seen_stall;
  logic        seen_moving;
  logic        seen_disabled;
  logic        seen_uninit;
  logic [15:0] blink_interval;

  // Checking mode of the item on the bus, moved along with the item itself.
  check_mode_t item_mode;
  led_result_t item_typed;

  led_result_t expected_leds[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic led_result_t leds(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [2:0] s);
    led_result_t res;
    res.red    = r;
    res.green  = g;
    res.blue   = b;
    res.status = s;
    return res;
  endfunction

  function automatic led_result_t status_colour(input logic [2:0] s);
    case (s)
      ST_IDLE:         return leds(8'd0,   8'd255, 8'd0,   s);
      ST_MOVING:       return leds(8'd0,   8'd0,   8'd255, s);
      ST_ERROR:        return leds(8'd255, 8'd0,   8'd0,   s);
      ST_STALL:        return leds(8'd255, 8'd255, 8'd0,   s);
      ST_INITIALIZING: return leds(8'd0,   8'd255, 8'd255, s);
      ST_DISABLED:     return leds(8'd255, 8'd165, 8'd0,   s);
      ST_WARNING:      return leds(8'd255, 8'd0,   8'd255, s);
      default:         return leds(8'd0,   8'd0,   8'd0,   s);
    endcase
  endfunction

  function automatic bit led_predict(input in_item_t it, output led_result_t res);
    logic [2:0]  next_code;
    int unsigned pos;
    res = '0;
    case (it.kind)
      KIND_AGGREGATE: begin
        seen_stall    |= it.stall_flag;
        seen_moving   |= it.moving_flag;
        seen_disabled |= ~it.enabled_flag;
        seen_uninit   |= ~it.initialized_flag;
        if (!it.last_report) return 1'b0;
        if (seen_stall) next_code = ST_STALL;
        else if (seen_moving) next_code = ST_MOVING;
        else if (seen_uninit) next_code = ST_INITIALIZING;
        else if (seen_disabled) next_code = ST_DISABLED;
        else next_code = ST_IDLE;
        seen_stall    = 1'b0;
        seen_moving   = 1'b0;
        seen_disabled = 1'b0;
        seen_uninit   = 1'b0;
        shown_code = next_code;
        res = status_colour(shown_code);
        return 1'b1;
      end
      KIND_SINGLE: begin
        if (!it.index_valid) next_code = ST_ERROR;
        else if (it.stall_flag) next_code = ST_STALL;
        else if (it.moving_flag) next_code = ST_MOVING;
        else if (!it.enabled_flag) next_code = ST_DISABLED;
        else if (!it.initialized_flag) next_code = ST_INITIALIZING;
        else next_code = ST_IDLE;
        shown_code = next_code;
        res = status_colour(shown_code);
        return 1'b1;
      end
      KIND_TICK: begin
        if (tick_count != TICK_TOP) tick_count++;
        if (blink_interval == 16'd0 || tick_count < blink_interval) return 1'b0;
        tick_count = 16'd0;
        blink_lit  = ~blink_lit;
        if (blink_lit) res = status_colour(shown_code);
        else res = leds(8'd0, 8'd0, 8'd0, shown_code);
        return 1'b1;
      end
      KIND_RGB: begin
        shown_code = ST_OFF;
        res = leds(it.rgb_red, it.rgb_green, it.rgb_blue, ST_OFF);
        return 1'b1;
      end
      KIND_WHEEL: begin
        shown_code = ST_OFF;
        pos = 255 - it.wheel_pos;
        if (pos < 85) begin
          res = leds(8'(255 - 3 * pos), 8'd0, 8'(3 * pos), ST_OFF);
        end else if (pos < 170) begin
          pos = pos - 85;
          res = leds(8'd0, 8'(3 * pos), 8'(255 - 3 * pos), ST_OFF);
        end else begin
          pos = pos - 170;
          res = leds(8'(3 * pos), 8'(255 - 3 * pos), 8'd0, ST_OFF);
        end
        return 1'b1;
      end
      KIND_SET_STATUS: begin
        shown_code = it.status_code;
        res = status_colour(shown_code);
        return 1'b1;
      end
      KIND_BLINK_RESTART: begin
        tick_count = 16'd0;
        blink_lit  = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return noise[$bits(in_item_t)-1:0];
  endfunction

  // Flags are packed as {stall, moving, enabled, initialized, index_valid, last_report}.
  function automatic directed_row_t dir_row(input logic [2:0] kind, input logic [5:0] flags,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] wp,
                                            input logic [2:0] code, input check_mode_t mode,
                                            input led_result_t typed);
    directed_row_t row;
    row.item  = {kind, flags, r, g, b, wp, code};
    row.mode  = mode;
    row.typed = typed;
    return row;
  endfunction

  task automatic send_item(input in_item_t it, input check_mode_t mode,
                           input led_result_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.kind             <= it.kind;
    in_ch.stall_flag       <= it.stall_flag;
    in_ch.moving_flag      <= it.moving_flag;
    in_ch.enabled_flag     <= it.enabled_flag;
    in_ch.initialized_flag <= it.initialized_flag;
    in_ch.index_valid      <= it.index_valid;
    in_ch.last_report      <= it.last_report;
    in_ch.rgb_red          <= it.rgb_red;
    in_ch.rgb_green        <= it.rgb_green;
    in_ch.rgb_blue         <= it.rgb_blue;
    in_ch.wheel_pos        <= it.wheel_pos;
    in_ch.status_code      <= it.status_code;
    item_mode              <= mode;
    item_typed             <= typed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_blink_interval(input logic [15:0] value);
    logic [15:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * REG_BLINK_INTERVAL);
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    blink_interval = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback != value) begin
      report_mismatch("blink_interval readback", 32'(readback), 32'(value));
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_item_t    taken;
    led_result_t predicted;
    led_result_t got;
    led_result_t want;
    bit          produces;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken = {in_ch.kind, in_ch.stall_flag, in_ch.moving_flag, in_ch.enabled_flag,
                 in_ch.initialized_flag, in_ch.index_valid, in_ch.last_report,
                 in_ch.rgb_red, in_ch.rgb_green, in_ch.rgb_blue, in_ch.wheel_pos,
                 in_ch.status_code};
        produces = led_predict(taken, predicted);
        case (item_mode)
          BY_PREDICTOR: if (produces) expected_leds.push_back(predicted);
          BY_TABLE:     expected_leds.push_back(item_typed);
          default:      ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = leds(out_ch.led_red, out_ch.led_green, out_ch.led_blue, out_ch.shown_status);
        if (expected_leds.size() == 0) begin
          report_mismatch("transfer with no result expected", 32'(got), 0);
        end else begin
          want = expected_leds.pop_front();
          if (got.red != want.red) begin
            report_mismatch("led_red", 32'(got.red), 32'(want.red));
          end
          if (got.green != want.green) begin
            report_mismatch("led_green", 32'(got.green), 32'(want.green));
          end
          if (got.blue != want.blue) begin
            report_mismatch("led_blue", 32'(got.blue), 32'(want.blue));
          end
          if (got.status != want.status) begin
            report_mismatch("shown_status", 32'(got.status), 32'(want.status));
          end
        end
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    in_item_t      it;
    int unsigned   phase;
    int unsigned   sent;
    int unsigned   run_len;
    int unsigned   pick;
    logic [15:0]   phase_interval;

    errors         = 0;
    shown_code     = ST_OFF;
    blink_lit      = 1'b0;
    tick_count     = 16'd0;
    seen_stall     = 1'b0;
    seen_moving    = 1'b0;
    seen_disabled  = 1'b0;
    seen_uninit    = 1'b0;
    blink_interval = 16'd0;
    send_idle_pct  = 30;
    recv_idle_pct  = 84;

    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.kind             <= KIND_AGGREGATE;
    in_ch.stall_flag       <= 1'b0;
    in_ch.moving_flag      <= 1'b0;
    in_ch.enabled_flag     <= 1'b0;
    in_ch.initialized_flag <= 1'b0;
    in_ch.index_valid      <= 1'b0;
    in_ch.last_report      <= 1'b0;
    in_ch.rgb_red          <= 8'd0;
    in_ch.rgb_green        <= 8'd0;
    in_ch.rgb_blue         <= 8'd0;
    in_ch.wheel_pos        <= 8'd0;
    in_ch.status_code      <= ST_OFF;
    item_mode    <= BY_PREDICTOR;
    item_typed   <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_blink_interval(16'd2);

    rows.push_back(dir_row(KIND_SINGLE, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd255, 8'd0, 8'd0, ST_ERROR)));
    rows.push_back(dir_row(KIND_SINGLE, 6'b100010, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd255, 8'd255, 8'd0, ST_STALL)));
    rows.push_back(dir_row(KIND_SINGLE, 6'b010010, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd0, 8'd0, 8'd255, ST_MOVING)));
    rows.push_back(dir_row(KIND_SINGLE, 6'b000110, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd255, 8'd165, 8'd0, ST_DISABLED)));
    rows.push_back(dir_row(KIND_SINGLE, 6'b001010, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd0, 8'd255, 8'd255, ST_INITIALIZING)));
    rows.push_back(dir_row(KIND_SINGLE, 6'b001110, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd0, 8'd255, 8'd0, ST_IDLE)));
    rows.push_back(dir_row(KIND_SINGLE, 6'b111101, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd255, 8'd0, 8'd0, ST_ERROR)));
    rows.push_back(dir_row(KIND_AGGREGATE, 6'b001110, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           NO_RESULT, '0));
    rows.push_back(dir_row(KIND_AGGREGATE, 6'b000110, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           NO_RESULT, '0));
    rows.push_back(dir_row(KIND_AGGREGATE, 6'b001011, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd0, 8'd255, 8'd255, ST_INITIALIZING)));
    rows.push_back(dir_row(KIND_AGGREGATE, 6'b011110, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           NO_RESULT, '0));
    rows.push_back(dir_row(KIND_AGGREGATE, 6'b100001, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd255, 8'd255, 8'd0, ST_STALL)));
    rows.push_back(dir_row(KIND_AGGREGATE, 6'b001101, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF, BY_TABLE,
                           leds(8'd0, 8'd255, 8'd0, ST_IDLE)));
    rows.push_back(dir_row(KIND_RGB, 6'b111111, 8'd255, 8'd255, 8'd255, 8'd255, ST_WARNING,
                           BY_TABLE, leds(8'd255, 8'd255, 8'd255, ST_OFF)));
    rows.push_back(dir_row(KIND_WHEEL, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_WHEEL, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd255, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_WHEEL, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd85, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_WHEEL, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd170, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_SET_STATUS, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_WARNING,
                           BY_TABLE, leds(8'd255, 8'd0, 8'd255, ST_WARNING)));
    rows.push_back(dir_row(KIND_TICK, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_TICK, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_TICK, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_BLINK_RESTART, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           NO_RESULT, '0));
    rows.push_back(dir_row(KIND_TICK, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_TICK, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_PREDICTOR, '0));
    rows.push_back(dir_row(KIND_UNUSED, 6'b111111, 8'd255, 8'd255, 8'd255, 8'd255, ST_WARNING,
                           NO_RESULT, '0));
    rows.push_back(dir_row(KIND_SET_STATUS, 6'b000000, 8'd0, 8'd0, 8'd0, 8'd0, ST_OFF,
                           BY_TABLE, leds(8'd0, 8'd0, 8'd0, ST_OFF)));

    foreach (rows[i]) send_item(rows[i].item, rows[i].mode, rows[i].typed);
    wait_quiet();

    for (phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0:       phase_interval = 16'd1;
        1:       phase_interval = 16'd0;
        2:       phase_interval = 16'd3;
        3:       phase_interval = TICK_TOP;
        4:       phase_interval = 16'($urandom_range(2, 5));
        default: phase_interval = 16'd1;
      endcase
      write_blink_interval(phase_interval);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          // An aggregate run, with the last-report marker now and then misplaced.
          run_len = $urandom_range(1, 6);
          for (int j = 0; j < run_len; j++) begin
            it = random_item();
            it.kind = KIND_AGGREGATE;
            it.last_report = (j == run_len - 1);
            if ($urandom_range(19) == 0) it.last_report = ~it.last_report;
            send_item(it, BY_PREDICTOR, '0);
          end
          sent += run_len;
        end else if (pick < 62) begin
          it = random_item();
          it.kind = KIND_TICK;
          send_item(it, BY_PREDICTOR, '0);
          sent++;
        end else if (pick < 66) begin
          it = random_item();
          it.kind = KIND_BLINK_RESTART;
          send_item(it, BY_PREDICTOR, '0);
          sent++;
        end else begin
          it = random_item();
          send_item(it, BY_PREDICTOR, '0);
          if (it.kind != KIND_UNUSED) sent++;
        end
      end
      wait_quiet();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
